// ===== hw/rtl/stack_calculator_engine_unit_assert.svh =====
`ifndef STACK_CALCULATOR_ENGINE_UNIT_ASSERT_SVH
`define STACK_CALCULATOR_ENGINE_UNIT_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define SCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define SCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sce_pkg.sv =====
`default_nettype none
package sce_pkg;
  localparam int DEPTH = 31;
  localparam int WIDTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DSW   = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CW-1:0]    count_t;
  typedef logic [AW-1:0]    addr_t;

  localparam logic [7:0] OP_PUSH  = 8'd1;
  localparam logic [7:0] OP_DPORT = 8'd2;
  localparam logic [7:0] OP_SPORT = 8'd3;
  localparam logic [7:0] OP_PEEK  = 8'd4;
  localparam logic [7:0] OP_DUMP  = 8'd5;
  localparam logic [7:0] OP_DUP   = 8'd6;
  localparam logic [7:0] OP_SWAP  = 8'd7;
  localparam logic [7:0] OP_NEG   = 8'd8;
  localparam logic [7:0] OP_FACT  = 8'd9;
  localparam logic [7:0] OP_SUM   = 8'd10;
  localparam logic [7:0] OP_ADD   = 8'd11;
  localparam logic [7:0] OP_SUB   = 8'd12;
  localparam logic [7:0] OP_MUL   = 8'd13;
  localparam logic [7:0] OP_DIV   = 8'd14;
  localparam logic [7:0] OP_MOD   = 8'd15;
  localparam logic [7:0] OP_AND   = 8'd16;
  localparam logic [7:0] OP_OR    = 8'd17;
  localparam logic [7:0] OP_SHL   = 8'd18;
  localparam logic [7:0] OP_SHR   = 8'd19;
  localparam logic [7:0] OP_CLEAR = 8'd254;
  localparam logic [7:0] OP_HALT  = 8'd255;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_FEW = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;
  localparam logic [1:0] ST_BAD = 2'd3;

  typedef enum logic [2:0] {ACC_HOLD, ACC_ZERO, ACC_FACT_INIT, ACC_ADD, ACC_MUL} acc_op_t;
  typedef enum logic [2:0] {WS_OPND, WS_TOP, WS_BELOW, WS_NEG, WS_ALU, WS_ACC, WS_DIV} wr_src_t;
  typedef enum logic [1:0] {WA_COUNT, WA_TOP, WA_BELOW, WA_ZERO} wr_addr_t;
  typedef enum logic [2:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR, CNT_ONE} cnt_op_t;
  typedef enum logic [1:0] {EM_NONE, EM_DATA_A, EM_DATA_B, EM_STATUS} emit_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    logic     walk_sel;
    logic     idx_clr;
    logic     idx_inc;
    acc_op_t  acc_op;
    logic     wr_en;
    wr_src_t  wr_src;
    wr_addr_t wr_addr;
    cnt_op_t  cnt_op;
    logic     set_dport;
    logic     set_sport;
    logic     set_halt;
    logic     st_set;
    logic [1:0] st_val;
    emit_t    emit;
    logic     div_start;
    logic     div_step;
  } cmd_t;

  typedef struct packed {
    logic [7:0] op;
    logic cnt_zero;
    logic cnt_lt2;
    logic cnt_full;
    logic b_neg;
    logic b_zero;
    logic walk_done;
    logic fact_done;
    logic div_done;
    logic out_free;
    logic halted;
  } stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/sce_datapath.sv =====
`default_nettype none
module sce_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         in_operation,
  input  wire logic signed [15:0] in_operand,
  input  wire sce_pkg::cmd_t      cmd,
  output sce_pkg::stat_t          stat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_port_number,
  output logic signed [15:0]      out_payload,
  output logic                    out_is_status,
  output logic                    out_last
);
  import sce_pkg::*;

  word_t      mem [DEPTH];
  word_t      rd_a_r, rd_b_r;
  logic [7:0] op_r;
  word_t      opnd_r;
  count_t     cnt_r, cnt_nxt, idx_r;
  word_t      acc_r, k_r;
  logic [7:0] dport_r, sport_r;
  logic       halted_r;
  logic [1:0] st_r;
  word_t      quo_r, rem_r;
  logic [DSW-1:0] dstep_r;
  logic       ov_r;
  logic [7:0] oport_r;
  word_t      opay_r;
  logic       ostat_r, olast_r;

  count_t     cnt_m1, cnt_m2;
  addr_t      top_addr, below_addr, addr_a, wr_addr;
  word_t      wr_data, alu_res, div_res, ma, mb, shifted, q_s, r_s;
  logic       na, nb, big, out_free;
  logic [WIDTH:0]   trial;
  logic [2*WIDTH-1:0] prod;

  assign cnt_m1     = cnt_r - CW'(1);
  assign cnt_m2     = cnt_r - CW'(2);
  assign top_addr   = cnt_m1[AW-1:0];
  assign below_addr = cnt_m2[AW-1:0];
  assign addr_a     = cmd.walk_sel ? idx_r[AW-1:0] : below_addr;

  assign na  = rd_a_r[WIDTH-1];
  assign nb  = rd_b_r[WIDTH-1];
  assign ma  = na ? -rd_a_r : rd_a_r;
  assign mb  = nb ? -rd_b_r : rd_b_r;
  assign big = nb || (rd_b_r >= WIDTH'(WIDTH));

  always_comb begin
    case (op_r)
      OP_ADD:  alu_res = rd_a_r + rd_b_r;
      OP_SUB:  alu_res = rd_a_r - rd_b_r;
      OP_MUL:  alu_res = WIDTH'(rd_a_r * rd_b_r);
      OP_AND:  alu_res = rd_a_r & rd_b_r;
      OP_OR:   alu_res = rd_a_r | rd_b_r;
      OP_SHL:  alu_res = big ? '0 : (rd_a_r << rd_b_r[DSW-2:0]);
      OP_SHR:  alu_res = big ? {WIDTH{na}} : word_t'($signed(rd_a_r) >>> rd_b_r[DSW-2:0]);
      default: alu_res = '0;
    endcase
  end

  assign shifted = {rem_r[WIDTH-2:0], quo_r[WIDTH-1]};
  assign trial   = {1'b0, shifted} - {1'b0, mb};
  assign q_s     = (na ^ nb) ? -quo_r : quo_r;
  assign r_s     = na ? -rem_r : rem_r;
  assign div_res = (op_r == OP_DIV) ? q_s : r_s;
  assign prod    = acc_r * k_r;

  always_comb begin
    case (cmd.wr_src)
      WS_OPND:  wr_data = opnd_r;
      WS_TOP:   wr_data = rd_b_r;
      WS_BELOW: wr_data = rd_a_r;
      WS_NEG:   wr_data = -rd_b_r;
      WS_ALU:   wr_data = alu_res;
      WS_ACC:   wr_data = acc_r;
      WS_DIV:   wr_data = div_res;
      default:  wr_data = '0;
    endcase
    case (cmd.wr_addr)
      WA_COUNT: wr_addr = cnt_r[AW-1:0];
      WA_TOP:   wr_addr = top_addr;
      WA_BELOW: wr_addr = below_addr;
      WA_ZERO:  wr_addr = '0;
      default:  wr_addr = '0;
    endcase
    case (cmd.cnt_op)
      CNT_INC: cnt_nxt = cnt_r + CW'(1);
      CNT_DEC: cnt_nxt = cnt_m1;
      CNT_CLR: cnt_nxt = '0;
      CNT_ONE: cnt_nxt = CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[top_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      opnd_r <= WIDTH'(in_operand);
    end
    case (cmd.acc_op)
      ACC_ZERO: acc_r <= '0;
      ACC_FACT_INIT: begin
        acc_r <= WIDTH'(1);
        k_r   <= WIDTH'(2);
      end
      ACC_ADD: acc_r <= acc_r + rd_a_r;
      ACC_MUL: begin
        acc_r <= prod[WIDTH-1:0];
        k_r   <= k_r + WIDTH'(1);
      end
      default: acc_r <= acc_r;
    endcase
    if (cmd.div_start) begin
      quo_r <= ma;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[WIDTH]) begin
        rem_r <= trial[WIDTH-1:0];
        quo_r <= {quo_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[WIDTH-2:0], 1'b0};
      end
    end
    if (cmd.emit != EM_NONE) begin
      case (cmd.emit)
        EM_DATA_A: begin
          oport_r <= dport_r;
          opay_r  <= rd_a_r;
          ostat_r <= 1'b0;
          olast_r <= 1'b0;
        end
        EM_DATA_B: begin
          oport_r <= dport_r;
          opay_r  <= rd_b_r;
          ostat_r <= 1'b0;
          olast_r <= 1'b0;
        end
        default: begin
          oport_r <= sport_r;
          opay_r  <= {{(WIDTH-2){1'b0}}, st_r};
          ostat_r <= 1'b1;
          olast_r <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      idx_r    <= '0;
      dport_r  <= 8'd1;
      sport_r  <= 8'd2;
      halted_r <= 1'b0;
      st_r     <= ST_OK;
      dstep_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.set_dport) begin
        dport_r <= opnd_r[7:0];
      end
      if (cmd.set_sport) begin
        sport_r <= opnd_r[7:0];
      end
      if (cmd.set_halt) begin
        halted_r <= 1'b1;
      end
      if (cmd.load) begin
        st_r <= ST_OK;
      end else if (cmd.st_set) begin
        st_r <= cmd.st_val;
      end
      if (cmd.div_start) begin
        dstep_r <= DSW'(WIDTH);
      end else if (cmd.div_step) begin
        dstep_r <= dstep_r - DSW'(1);
      end
      if (cmd.emit != EM_NONE) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_free = !ov_r || !out_stall;

  always_comb begin
    stat.op        = op_r;
    stat.cnt_zero  = (cnt_r == '0);
    stat.cnt_lt2   = (cnt_r < CW'(2));
    stat.cnt_full  = (cnt_r == CW'(DEPTH));
    stat.b_neg     = nb;
    stat.b_zero    = (rd_b_r == '0);
    stat.walk_done = (idx_r >= cnt_r);
    stat.fact_done = (k_r > rd_b_r) || (acc_r == '0);
    stat.div_done  = (dstep_r == '0);
    stat.out_free  = out_free;
    stat.halted    = halted_r;
  end

  assign out_valid       = ov_r;
  assign out_port_number = oport_r;
  assign out_payload     = opay_r;
  assign out_is_status   = ostat_r;
  assign out_last        = olast_r;

`include "stack_calculator_engine_unit_assert.svh"
  `SCE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH), "entry count beyond depth")
  `SCE_ASSERT_IMP(a_wr_bound, cmd.wr_en, CW'(wr_addr) < CW'(DEPTH), "stack write out of range")
endmodule
`default_nettype wire

// ===== hw/rtl/sce_controller.sv =====
`default_nettype none
module sce_controller (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire sce_pkg::stat_t stat,
  output sce_pkg::cmd_t       cmd
);
  import sce_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECODE = 11'b00000000010,
    S_PEEK   = 11'b00000000100,
    S_WREQ   = 11'b00000001000,
    S_WOUT   = 11'b00000010000,
    S_SUMWR  = 11'b00000100000,
    S_FACT   = 11'b00001000000,
    S_DIV    = 11'b00010000000,
    S_SWAP2  = 11'b00100000000,
    S_STATUS = 11'b01000000000,
    S_SPARE  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.rd_en = 1'b1;
        if (in_valid && !stat.halted) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_STATUS;
        cmd.st_set = 1'b1;
        cmd.st_val = ST_OK;
        case (stat.op)
          OP_PUSH: begin
            if (stat.cnt_full) begin
              cmd.st_val = ST_OVF;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_src  = WS_OPND;
              cmd.wr_addr = WA_COUNT;
              cmd.cnt_op  = CNT_INC;
            end
          end
          OP_DPORT: cmd.set_dport = 1'b1;
          OP_SPORT: cmd.set_sport = 1'b1;
          OP_PEEK: begin
            if (stat.cnt_zero) begin
              cmd.st_val = ST_FEW;
            end else begin
              state_nxt = S_PEEK;
            end
          end
          OP_DUMP: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_WREQ;
          end
          OP_DUP: begin
            if (stat.cnt_zero) begin
              cmd.st_val = ST_FEW;
            end else if (stat.cnt_full) begin
              cmd.st_val = ST_OVF;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_src  = WS_TOP;
              cmd.wr_addr = WA_COUNT;
              cmd.cnt_op  = CNT_INC;
            end
          end
          OP_SWAP: begin
            if (stat.cnt_lt2) begin
              cmd.st_val = ST_FEW;
              cmd.cnt_op = CNT_CLR;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_src  = WS_BELOW;
              cmd.wr_addr = WA_TOP;
              state_nxt   = S_SWAP2;
            end
          end
          OP_NEG: begin
            if (stat.cnt_zero) begin
              cmd.st_val = ST_FEW;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_src  = WS_NEG;
              cmd.wr_addr = WA_TOP;
            end
          end
          OP_FACT: begin
            if (stat.cnt_zero) begin
              cmd.st_val = ST_FEW;
            end else if (stat.b_neg) begin
              cmd.st_val = ST_OVF;
            end else begin
              cmd.acc_op = ACC_FACT_INIT;
              state_nxt  = S_FACT;
            end
          end
          OP_SUM: begin
            if (stat.cnt_zero) begin
              cmd.st_val = ST_FEW;
            end else begin
              cmd.idx_clr = 1'b1;
              cmd.acc_op  = ACC_ZERO;
              state_nxt   = S_WREQ;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_SHL, OP_SHR: begin
            if (stat.cnt_lt2) begin
              cmd.st_val = ST_FEW;
              cmd.cnt_op = CNT_CLR;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_src  = WS_ALU;
              cmd.wr_addr = WA_BELOW;
              cmd.cnt_op  = CNT_DEC;
            end
          end
          OP_DIV, OP_MOD: begin
            if (stat.cnt_lt2) begin
              cmd.st_val = ST_FEW;
              cmd.cnt_op = CNT_CLR;
            end else if (stat.b_zero) begin
              cmd.st_val = ST_OVF;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          OP_CLEAR: cmd.cnt_op   = CNT_CLR;
          OP_HALT:  cmd.set_halt = 1'b1;
          default:  cmd.st_val   = ST_BAD;
        endcase
      end
      S_PEEK: begin
        if (stat.out_free) begin
          cmd.emit  = EM_DATA_B;
          state_nxt = S_STATUS;
        end
      end
      S_WREQ: begin
        cmd.rd_en    = 1'b1;
        cmd.walk_sel = 1'b1;
        if (stat.walk_done) begin
          state_nxt = (stat.op == OP_SUM) ? S_SUMWR : S_STATUS;
        end else begin
          state_nxt = S_WOUT;
        end
      end
      S_WOUT: begin
        cmd.walk_sel = 1'b1;
        if (stat.op == OP_SUM) begin
          cmd.acc_op  = ACC_ADD;
          cmd.idx_inc = 1'b1;
          state_nxt   = S_WREQ;
        end else if (stat.out_free) begin
          cmd.emit    = EM_DATA_A;
          cmd.idx_inc = 1'b1;
          state_nxt   = S_WREQ;
        end
      end
      S_SUMWR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WS_ACC;
        cmd.wr_addr = WA_ZERO;
        cmd.cnt_op  = CNT_ONE;
        state_nxt   = S_STATUS;
      end
      S_FACT: begin
        if (stat.fact_done) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_src  = WS_ACC;
          cmd.wr_addr = WA_TOP;
          state_nxt   = S_STATUS;
        end else begin
          cmd.acc_op = ACC_MUL;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_src  = WS_DIV;
          cmd.wr_addr = WA_BELOW;
          cmd.cnt_op  = CNT_DEC;
          state_nxt   = S_STATUS;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_SWAP2: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WS_TOP;
        cmd.wr_addr = WA_BELOW;
        state_nxt   = S_STATUS;
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.emit  = EM_STATUS;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`include "stack_calculator_engine_unit_assert.svh"
  `SCE_ASSERT_IMP(a_emit_free, cmd.emit != EM_NONE, stat.out_free, "word emitted into a full output")
  `SCE_ASSERT_NEXT(a_load_decode, cmd.load, state_r == S_DECODE, "loaded command not decoded")
  `SCE_ASSERT_IMP(a_div_nonzero, state_r == S_DIV, !stat.b_zero, "division by zero started")
endmodule
`default_nettype wire

// ===== hw/rtl/stack_calculator_engine_unit.sv =====
`default_nettype none
// RPN stack calculator. A command word (operation, operand) enters on the in_
// channel; results leave on the out_ channel, stack values to the data port
// followed by one status word to the status port, flagged by out_last.
// One command is worked on at a time: in_stall is high from acceptance until
// its status word has been loaded into the output register. Simple commands
// pass through a decode and a status state before the next command word can
// be accepted. Peek adds a state that emits the top entry, a dump or sum
// reads each stack entry in turn through the single walk read port, a
// factorial does one multiply per cycle, and divide or mod runs the
// bit-serial restoring divider.
// The output register lets a word wait while the next step proceeds; a stall
// on out_ holds that word and pauses a peek, the dump walk or the status step until taken.
// Reset (synchronous, rst_n low) empties the stack, sets the data port to 1,
// the status port to 2 and clears the halt flag. After halt, command words
// are still accepted but dropped with no result until the next reset.
module stack_calculator_engine_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_operation,
  input  wire logic signed [15:0] in_operand,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_port_number,
  output logic signed [15:0]      out_payload,
  output logic                    out_is_status,
  output logic                    out_last
);
  import sce_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sce_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sce_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_operation),
    .in_operand      (in_operand),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_port_number (out_port_number),
    .out_payload     (out_payload),
    .out_is_status   (out_is_status),
    .out_last        (out_last)
  );
endmodule
`default_nettype wire
